// ===== src/ttse_pkg.sv =====
// ttse_pkg: shared types, codes and constants of the task table sleep engine
// used by the front, back and top of the block; no dependencies
`default_nettype none

package ttse_pkg;

    // default table size and fixed limits
    localparam int SLOTS_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [31:0] FIRST_ID = 32'd1;

    // action codes on the input
    localparam logic [2:0] ACT_CREATE = 3'd0;
    localparam logic [2:0] ACT_SLEEP  = 3'd1;
    localparam logic [2:0] ACT_EXIT   = 3'd2;
    localparam logic [2:0] ACT_TICK   = 3'd3;
    localparam logic [2:0] ACT_LOOKUP = 3'd4;

    // result kinds
    localparam logic [2:0] K_CREATED = 3'd0;
    localparam logic [2:0] K_FULL    = 3'd1;
    localparam logic [2:0] K_WOKEN   = 3'd2;
    localparam logic [2:0] K_FOUND   = 3'd3;
    localparam logic [2:0] K_MISSING = 3'd4;
    localparam logic [2:0] K_DONE    = 3'd5;

    // slot states
    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_READY  = 2'd1;
    localparam logic [1:0] ST_SLEEP  = 2'd2;
    localparam logic [1:0] ST_ZOMBIE = 2'd3;

    typedef enum logic [2:0] {
        OP_CREATE,
        OP_SLEEP,
        OP_EXIT,
        OP_TICK,
        OP_LOOKUP,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  new_priority;
        logic [31:0] sleep_length;
        logic [3:0]  target_slot;
        logic [31:0] wanted_id;
    } t_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot_index;
        logic [31:0] task_id;
        logic [7:0]  task_priority;
        logic [1:0]  slot_state;
        logic        last;
    } t_result;

    // classified command handed from front to back
    typedef struct packed {
        t_op         op;
        logic        slot_ok;
        logic [7:0]  new_priority;
        logic [31:0] sleep_length;
        logic [3:0]  target_slot;
        logic [31:0] wanted_id;
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/ttse_fifo.sv =====
// ttse_fifo: small flop-based queue of fixed-width words
// depends on nothing
`default_nettype none

module ttse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ttse_front.sv =====
// ttse_front: input stage, decodes the action and range-checks the target slot
// depends on ttse_pkg
`default_nettype none

module ttse_front
    import ttse_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    output logic       o_full,
    input  wire t_item i_item,
    output logic       o_cmd_push,
    input  wire logic  i_cmd_full,
    output t_cmd       o_cmd
);

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  accept;

    assign o_full     = r_valid && i_cmd_full;
    assign accept     = i_push && !o_full;
    assign o_cmd_push = r_valid;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd              = '0;
        n_cmd.new_priority = i_item.new_priority;
        n_cmd.sleep_length = i_item.sleep_length;
        n_cmd.target_slot  = i_item.target_slot;
        n_cmd.wanted_id    = i_item.wanted_id;
        n_cmd.slot_ok      = (32'(i_item.target_slot) < 32'(SLOTS));
        unique case (i_item.action)
            ACT_CREATE: n_cmd.op = OP_CREATE;
            ACT_SLEEP:  n_cmd.op = OP_SLEEP;
            ACT_EXIT:   n_cmd.op = OP_EXIT;
            ACT_TICK:   n_cmd.op = OP_TICK;
            ACT_LOOKUP: n_cmd.op = OP_LOOKUP;
            default:    n_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && i_cmd_full);
        end
    end

endmodule

`default_nettype wire

// ===== src/ttse_back.sv =====
// ttse_back: slot table and scan sequencer that carries out each command
// depends on ttse_pkg
`default_nettype none

module ttse_back
    import ttse_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_cmd_empty,
    output logic      o_cmd_pop,
    output t_result   o_res,
    output logic      o_res_push,
    input  wire logic i_res_full
);

    localparam int SW  = $clog2(SLOTS);
    localparam int WCW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    // table stores, no reset: their values are only used for slots that were written
    logic [31:0] mem_id   [SLOTS];
    logic [7:0]  mem_prio [SLOTS];
    logic [31:0] mem_left [SLOTS];

    logic [1:0]  r_status [SLOTS];

    t_state      r_state;
    t_cmd        r_cmd;
    logic [SW-1:0] r_addr;
    logic [SW-1:0] r_last_addr;
    logic        r_issued;
    logic        r_v2;
    logic [SW-1:0] r_idx2;
    logic [31:0] r_id_q;
    logic [7:0]  r_prio_q;
    logic [31:0] r_left_q;
    logic        r_pend_v;
    t_result     r_pend;
    logic [WCW-1:0] r_wake_cnt;
    logic [31:0] r_id_ctr;

    logic [1:0]  st2;
    logic [31:0] dec_left;
    logic        cand_v;
    t_result     cand;
    logic        wr_id, wr_prio, wr_left, wr_st;
    logic [31:0] new_left;
    logic [1:0]  new_st;
    logic        stop;
    logic        wake_cnt_inc;
    logic        ctr_inc;
    logic        stall;
    logic        go;
    logic        rd_en;
    logic        is_slot_op;
    t_result     dflt;

    assign st2        = r_status[r_idx2];
    assign dec_left   = (r_left_q != '0) ? r_left_q - 32'd1 : '0;
    assign is_slot_op = (i_cmd.op == OP_SLEEP) || (i_cmd.op == OP_EXIT);
    assign o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;

    // stage two: act on the slot whose stores were read into the stage registers
    always_comb begin
        cand_v       = 1'b0;
        cand         = '0;
        wr_id        = 1'b0;
        wr_prio      = 1'b0;
        wr_left      = 1'b0;
        wr_st        = 1'b0;
        new_left     = dec_left;
        new_st       = st2;
        stop         = 1'b0;
        wake_cnt_inc = 1'b0;
        ctr_inc      = 1'b0;
        if (r_state == S_SCAN && r_v2) begin
            unique case (r_cmd.op)
                OP_CREATE: begin
                    if (st2 == ST_FREE) begin
                        wr_id    = 1'b1;
                        wr_prio  = 1'b1;
                        wr_st    = 1'b1;
                        new_st   = ST_READY;
                        ctr_inc  = 1'b1;
                        stop     = 1'b1;
                        cand_v   = 1'b1;
                        cand     = '{K_CREATED, 4'(r_idx2), r_id_ctr,
                                     r_cmd.new_priority, ST_READY, 1'b0};
                    end
                end
                OP_LOOKUP: begin
                    if (st2 != ST_FREE && r_id_q == r_cmd.wanted_id) begin
                        stop   = 1'b1;
                        cand_v = 1'b1;
                        cand   = '{K_FOUND, 4'(r_idx2), r_id_q, r_prio_q, st2, 1'b0};
                    end
                end
                OP_SLEEP: begin
                    if (st2 == ST_READY || st2 == ST_SLEEP) begin
                        wr_left  = 1'b1;
                        new_left = r_cmd.sleep_length;
                        wr_st    = 1'b1;
                        new_st   = ST_SLEEP;
                        cand_v   = 1'b1;
                        cand     = '{K_DONE, 4'(r_idx2), r_id_q, r_prio_q, ST_SLEEP, 1'b0};
                    end
                end
                OP_EXIT: begin
                    if (st2 == ST_READY || st2 == ST_SLEEP) begin
                        wr_st  = 1'b1;
                        new_st = ST_ZOMBIE;
                        cand_v = 1'b1;
                        cand   = '{K_DONE, 4'(r_idx2), r_id_q, r_prio_q, ST_ZOMBIE, 1'b0};
                    end
                end
                OP_TICK: begin
                    if (st2 == ST_SLEEP) begin
                        wr_left = 1'b1;
                        if (dec_left == '0) begin
                            wr_st  = 1'b1;
                            new_st = ST_READY;
                            // only the first MAX_RESULTS wakeups of one tick are reported
                            if (r_wake_cnt < WCW'(MAX_RESULTS)) begin
                                wake_cnt_inc = 1'b1;
                                cand_v       = 1'b1;
                                cand         = '{K_WOKEN, 4'(r_idx2), r_id_q, r_prio_q,
                                                 ST_READY, 1'b0};
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // a new result displaces the held one, which then must go out
    assign stall = cand_v && r_pend_v && i_res_full;
    assign go    = !stall;
    assign rd_en = (r_state == S_SCAN) && go && !stop && !r_issued;

    always_comb begin
        dflt            = '0;
        dflt.last       = 1'b1;
        unique case (r_cmd.op)
            OP_CREATE: dflt.kind = K_FULL;
            OP_LOOKUP: dflt.kind = K_MISSING;
            OP_SLEEP, OP_EXIT: begin
                dflt.kind       = K_DONE;
                dflt.slot_index = r_cmd.target_slot;
            end
            default:   dflt.kind = K_DONE;
        endcase
    end

    always_comb begin
        if (r_state == S_FLUSH) begin
            o_res      = r_pend_v ? r_pend : dflt;
            o_res.last = 1'b1;
            o_res_push = !i_res_full;
        end else begin
            o_res      = r_pend;
            o_res.last = 1'b0;
            o_res_push = (r_state == S_SCAN) && go && cand_v && r_pend_v;
        end
    end

    // table memories: one read address and one write address per cycle
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_id_q   <= mem_id[r_addr];
            r_prio_q <= mem_prio[r_addr];
            r_left_q <= mem_left[r_addr];
        end
        if (go && wr_id) begin
            mem_id[r_idx2] <= r_id_ctr;
        end
        if (go && wr_prio) begin
            mem_prio[r_idx2] <= r_cmd.new_priority;
        end
        if (go && wr_left) begin
            mem_left[r_idx2] <= new_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_v2       <= 1'b0;
            r_issued   <= 1'b0;
            r_pend_v   <= 1'b0;
            r_wake_cnt <= '0;
            r_id_ctr   <= FIRST_ID;
            for (int i = 0; i < SLOTS; i++) begin
                r_status[i] <= ST_FREE;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd      <= i_cmd;
                        r_pend_v   <= 1'b0;
                        r_wake_cnt <= '0;
                        r_v2       <= 1'b0;
                        r_issued   <= 1'b0;
                        if (is_slot_op) begin
                            r_addr      <= SW'(i_cmd.target_slot);
                            r_last_addr <= SW'(i_cmd.target_slot);
                        end else begin
                            r_addr      <= '0;
                            r_last_addr <= SW'(SLOTS - 1);
                        end
                        if (i_cmd.op == OP_NOP || (is_slot_op && !i_cmd.slot_ok)) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (go) begin
                        if (stop) begin
                            r_v2    <= 1'b0;
                            r_state <= S_FLUSH;
                        end else if (!r_issued) begin
                            r_v2     <= 1'b1;
                            r_idx2   <= r_addr;
                            r_addr   <= r_addr + 1'b1;
                            r_issued <= (r_addr == r_last_addr);
                        end else begin
                            r_v2 <= 1'b0;
                            if (!r_v2) begin
                                r_state <= S_FLUSH;
                            end
                        end
                        if (cand_v) begin
                            r_pend   <= cand;
                            r_pend_v <= 1'b1;
                        end
                        if (wr_st) begin
                            r_status[r_idx2] <= new_st;
                        end
                        if (ctr_inc) begin
                            r_id_ctr <= r_id_ctr + 32'd1;
                        end
                        if (wake_cnt_inc) begin
                            r_wake_cnt <= r_wake_cnt + 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!i_res_full) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/task_table_sleep_engine_top.sv =====
// task table sleep engine: a full scan walks every slot, a create or lookup stops at its
// hit slot, sleep and exit touch only their target slot; the slot table read port gives
// one slot per cycle unless a full result queue stalls the scan; the back starts a new
// item only after the final result of the last one; reset: synchronous active low, all
// slots free, id at one
// depends on ttse_pkg, ttse_fifo, ttse_front, ttse_back
`default_nettype none

module task_table_sleep_engine_top
    import ttse_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    // input side: queue-style push/full
    input  wire logic    push,
    output logic         full,
    input  wire t_item   i_item,
    // result side: queue-style empty/pop
    output logic         empty,
    input  wire logic    pop,
    output t_result      o_result
);

    // front to back command queue
    t_cmd    front_cmd;
    logic    cmd_push;
    logic    cmd_full;
    logic    cmd_empty;
    logic    cmd_pop;
    t_cmd    back_cmd;
    logic [$bits(t_cmd)-1:0] cmd_q_out;

    // back to output result queue
    t_result back_res;
    logic    res_push;
    logic    res_full;
    logic [$bits(t_result)-1:0] res_q_out;

    // front decodes the action and checks the slot range
    ttse_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .o_cmd_push (cmd_push),
        .i_cmd_full (cmd_full),
        .o_cmd      (front_cmd)
    );

    // short queue so the front keeps taking items while the back scans
    ttse_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .o_full  (cmd_full),
        .i_data  (front_cmd),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_q_out)
    );

    assign back_cmd = t_cmd'(cmd_q_out);

    // back owns the slot table and walks it one slot per cycle while the scan is not stalled
    ttse_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (back_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    // result queue decouples the scan from a stalled consumer
    ttse_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .o_full  (res_full),
        .i_data  (back_res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_q_out)
    );

    assign o_result = t_result'(res_q_out);

    // back never offers a result into a full queue
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result transfer offered while result queue full");

    // front holds its command while the queue is full
    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_push && cmd_full) |=> (cmd_push && $stable(front_cmd)))
        else $error("front dropped a stalled command");

    // only kinds that are defined leave the block
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.kind <= K_DONE))
        else $error("undefined result kind");

    // single-result kinds always close their item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.kind == K_CREATED || o_result.kind == K_FULL ||
                    o_result.kind == K_FOUND || o_result.kind == K_MISSING))
        |-> o_result.last)
        else $error("single result without last");

endmodule

`default_nettype wire

// ===== verif/tb_task_table_sleep_engine_top.sv =====
// testbench for task_table_sleep_engine_top: directed and random task-table actions,
// results checked in order against a scoreboard that tracks slot states and ids
// depends on ttse_pkg and the task_table_sleep_engine_top rtl
module tb_task_table_sleep_engine_top;
    import ttse_pkg::*;

    // spare action codes, the block answers them with a plain done
    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    // cycles to let pass once the last expected result is in (full scan plus queues)
    localparam int SETTLE_CYCLES = 3 * SLOTS_DEF;
    // receiver hold-off used to back the block up
    localparam int HOLD_CYCLES   = 250;
    // watchdog: cycles with no transfer on either side
    localparam int IDLE_LIMIT    = 3000;
    localparam int RANDOM_ITEMS  = 55;

    // ------------------------------------------------------------------
    // scoreboard: own copy of the slot table, expected results in order
    // ------------------------------------------------------------------
    class task_table_tracker;
        logic [1:0]  state_of  [SLOTS_DEF];
        logic [31:0] id_of     [SLOTS_DEF];
        logic [7:0]  prio_of   [SLOTS_DEF];
        logic [31:0] countdown [SLOTS_DEF];
        logic [31:0] next_id;
        t_result     pending_reports[$];
        int          mismatch_count;

        function new();
            for (int s = 0; s < SLOTS_DEF; s++) begin
                state_of[s]  = ST_FREE;
                id_of[s]     = '0;
                prio_of[s]   = '0;
                countdown[s] = '0;
            end
            next_id        = FIRST_ID;
            mismatch_count = 0;
        endfunction

        function t_result blank_report(logic [2:0] kind, logic [3:0] slot);
            t_result r;
            r            = '0;
            r.kind       = kind;
            r.slot_index = slot;
            return r;
        endfunction

        function t_result slot_report(logic [2:0] kind, int s);
            t_result r;
            r               = '0;
            r.kind          = kind;
            r.slot_index    = s[3:0];
            r.task_id       = id_of[s];
            r.task_priority = prio_of[s];
            r.slot_state    = state_of[s];
            return r;
        endfunction

        // update the table for one accepted item and queue what it should report
        function void apply_action(t_item it);
            t_result batch[$];
            t_result r;
            int      hit;
            int      s;
            hit = -1;
            s   = int'(it.target_slot);
            case (it.action)
                ACT_CREATE: begin
                    for (int i = 0; i < SLOTS_DEF && hit < 0; i++)
                        if (state_of[i] == ST_FREE) hit = i;
                    if (hit < 0) begin
                        batch.push_back(blank_report(K_FULL, '0));
                    end else begin
                        id_of[hit]     = next_id;
                        next_id        = next_id + 32'd1;
                        prio_of[hit]   = it.new_priority;
                        state_of[hit]  = ST_READY;
                        countdown[hit] = '0;
                        batch.push_back(slot_report(K_CREATED, hit));
                    end
                end
                ACT_SLEEP, ACT_EXIT: begin
                    if (s < SLOTS_DEF &&
                        (state_of[s] == ST_READY || state_of[s] == ST_SLEEP)) begin
                        if (it.action == ACT_SLEEP) begin
                            countdown[s] = it.sleep_length;
                            state_of[s]  = ST_SLEEP;
                        end else begin
                            state_of[s] = ST_ZOMBIE;
                        end
                        batch.push_back(slot_report(K_DONE, s));
                    end else begin
                        batch.push_back(blank_report(K_DONE, it.target_slot));
                    end
                end
                ACT_TICK: begin
                    for (int i = 0; i < SLOTS_DEF; i++) begin
                        if (state_of[i] == ST_SLEEP) begin
                            if (countdown[i] != 0) countdown[i] = countdown[i] - 32'd1;
                            if (countdown[i] == 0) begin
                                state_of[i] = ST_READY;
                                if (batch.size() < MAX_RESULTS)
                                    batch.push_back(slot_report(K_WOKEN, i));
                            end
                        end
                    end
                    if (batch.size() == 0) batch.push_back(blank_report(K_DONE, '0));
                end
                ACT_LOOKUP: begin
                    for (int i = 0; i < SLOTS_DEF && hit < 0; i++)
                        if (state_of[i] != ST_FREE && id_of[i] == it.wanted_id) hit = i;
                    if (hit < 0) batch.push_back(blank_report(K_MISSING, '0));
                    else         batch.push_back(slot_report(K_FOUND, hit));
                end
                default: begin
                    batch.push_back(blank_report(K_DONE, '0));
                end
            endcase
            r      = batch.pop_back();
            r.last = 1'b1;
            batch.push_back(r);
            foreach (batch[k]) pending_reports.push_back(batch[k]);
        endfunction

        function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: mismatch on %s: expected %h, actual %h",
                         $time, name, want, got);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // compare one accepted result with the oldest expectation
        function void match_result(t_result got);
            t_result want;
            bit      bad;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                mismatch_count++;
                return;
            end
            want = pending_reports.pop_front();
            bad  = 1'b0;
            bad  = field_differs("kind", 32'(want.kind), 32'(got.kind)) | bad;
            bad  = field_differs("slot_index", 32'(want.slot_index), 32'(got.slot_index)) | bad;
            bad  = field_differs("task_id", want.task_id, got.task_id) | bad;
            bad  = field_differs("task_priority", 32'(want.task_priority),
                                 32'(got.task_priority)) | bad;
            bad  = field_differs("slot_state", 32'(want.slot_state), 32'(got.slot_state)) | bad;
            bad  = field_differs("last", 32'(want.last), 32'(got.last)) | bad;
            if (bad) mismatch_count++;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block
    // ------------------------------------------------------------------
    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push = 1'b0;
    logic    full;
    t_item   i_item = '0;
    logic    empty;
    logic    pop = 1'b0;
    t_result o_result;

    task_table_tracker tracker = new();

    // sender and receiver both read these
    bit no_idle       = 1'b0;   // burst stretch: no gaps on either side
    bit stall_request = 1'b0;   // ask the receiver for one long hold-off
    int idle_cycles   = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task_table_sleep_engine_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // gap length: mostly none or short, now and then long
    function int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // one transfer on the input; push stays high when the next item follows at once
    task send_item(input t_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        tracker.apply_action(it);
    endtask

    // item with every field random, the caller sets what the action needs
    function t_item noisy_item(logic [2:0] act);
        t_item it;
        it.action       = act;
        it.new_priority = 8'($urandom);
        it.sleep_length = $urandom;
        it.target_slot  = 4'($urandom);
        it.wanted_id    = $urandom;
        return it;
    endfunction

    task send_create(input logic [7:0] prio);
        t_item it;
        it              = noisy_item(ACT_CREATE);
        it.new_priority = prio;
        send_item(it);
    endtask

    task send_sleep(input logic [3:0] slot, input logic [31:0] len);
        t_item it;
        it              = noisy_item(ACT_SLEEP);
        it.target_slot  = slot;
        it.sleep_length = len;
        send_item(it);
    endtask

    task send_exit(input logic [3:0] slot);
        t_item it;
        it             = noisy_item(ACT_EXIT);
        it.target_slot = slot;
        send_item(it);
    endtask

    task send_tick();
        send_item(noisy_item(ACT_TICK));
    endtask

    task send_lookup(input logic [31:0] id);
        t_item it;
        it           = noisy_item(ACT_LOOKUP);
        it.wanted_id = id;
        send_item(it);
    endtask

    // sender pauses until every expected result is in, then lets the block settle
    task drain_results();
        push <= 1'b0;
        while (tracker.pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random action: mostly sleep/tick traffic on random slots, some lookups and noise
    task send_random_item();
        int          r;
        int          pick;
        logic [31:0] len;
        logic [31:0] id;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      len = $urandom_range(0, 3);
            else if (pick < 92) len = $urandom_range(4, 20);
            else                len = $urandom;
            send_sleep(4'($urandom), len);
        end else if (r < 65) begin
            send_tick();
        end else if (r < 85) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)      id = tracker.id_of[$urandom_range(0, SLOTS_DEF - 1)];
            else if (pick < 8) id = tracker.next_id - 32'd1;
            else               id = $urandom;
            send_lookup(id);
        end else if (r < 92) begin
            send_create(8'($urandom));
        end else if (r < 96) begin
            send_exit(4'($urandom));
        end else begin
            // spare codes
            pick = $urandom_range(0, 2);
            case (pick)
                0:       send_item(noisy_item(ACT_SPARE_5));
                1:       send_item(noisy_item(ACT_SPARE_6));
                default: send_item(noisy_item(ACT_SPARE_7));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // receiver side: random pops, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (stall_request) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                stall_request = 1'b0;
            end
            gap = pick_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            tracker.match_result(o_result);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: any cycle without a transfer counts toward the limit
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("tb_task_table_sleep_engine_top failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: tick with nobody woken, lookup miss on id zero,
        // sleep and exit on free slots, spare codes
        send_tick();
        send_lookup(32'h0000_0000);
        send_sleep(4'd5, 32'd3);
        send_exit(4'd15);
        send_item(noisy_item(ACT_SPARE_5));
        send_item(noisy_item(ACT_SPARE_7));

        // first tasks, priority extremes
        send_create(8'h00);
        send_create(8'hFF);
        send_create(8'hA5);
        send_lookup(32'd1);
        send_lookup(32'hFFFF_FFFF);

        // sleep of length zero wakes at the next tick; longer counts down
        send_sleep(4'd0, 32'd0);
        send_sleep(4'd1, 32'd2);
        send_sleep(4'd2, 32'hFFFF_FFFF);
        send_tick();
        send_tick();
        send_lookup(32'd3);
        drain_results();

        // fill the table, then one create past full
        repeat (SLOTS_DEF - 3) send_create(8'($urandom));
        send_create(8'h5A);

        // receiver holds off while every slot is put to sleep back to back,
        // so the block backs up and stalls its input
        no_idle       = 1'b1;
        stall_request = 1'b1;
        for (int s = 0; s < SLOTS_DEF; s++) send_sleep(4'(s), 32'd0);
        // one tick wakes all sixteen
        send_tick();
        no_idle = 1'b0;
        drain_results();

        // exit on ready and sleeping slots, then act on the zombies
        send_exit(4'd1);
        send_sleep(4'd2, 32'd5);
        send_exit(4'd2);
        send_sleep(4'd1, 32'd1);
        send_exit(4'd2);
        send_lookup(32'd2);
        drain_results();

        // random traffic, with burst stretches now and then
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_random_item();
        end
        no_idle = 1'b0;
        drain_results();

        if (tracker.mismatch_count == 0 && tracker.pending_reports.size() == 0) begin
            $display("tb_task_table_sleep_engine_top passed");
        end else begin
            $display("tb_task_table_sleep_engine_top failed");
        end
        $finish;
    end

endmodule

// ===== task_table_sleep_engine_top.f =====
src/ttse_pkg.sv
src/ttse_fifo.sv
src/ttse_front.sv
src/ttse_back.sv
src/task_table_sleep_engine_top.sv
verif/tb_task_table_sleep_engine_top.sv
